// File: hw/rtl/gn2d_pkg.sv
// gn2d_pkg: shared constants and types for the 2D gradient noise core.
// No dependencies.
package gn2d_pkg;

    localparam int TABLE_SIZE     = 256;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COORD_W        = 32;

    localparam logic [1:0] OP_LOAD_PERM = 2'd0;
    localparam logic [1:0] OP_LOAD_GRAD = 2'd1;
    localparam logic [1:0] OP_EVAL      = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  table_index;
        logic [7:0]  perm_value;
        logic [15:0] grad_x;
        logic [15:0] grad_y;
        logic [31:0] coord_x;
        logic [31:0] coord_y;
    } gn2d_item_t;

endpackage

// File: hw/rtl/gn2d_front.sv
// gn2d_front: accepts items, classifies them, drops op 3 and pushes the rest into a two-entry queue.
// Depends on gn2d_pkg.
module gn2d_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  gn2d_pkg::gn2d_item_t in_item,
    output logic                q_valid,
    input  logic                q_ready,
    output gn2d_pkg::gn2d_item_t q_item
);
    gn2d_pkg::gn2d_item_t buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop, useful;

    assign useful   = (in_item.op == gn2d_pkg::OP_LOAD_PERM) ||
                      (in_item.op == gn2d_pkg::OP_LOAD_GRAD) ||
                      (in_item.op == gn2d_pkg::OP_EVAL);
    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && useful;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = buf_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !push) else $error("push into full queue");
endmodule

// File: hw/rtl/gn2d_back.sv
// gn2d_back: table storage and the pipelined noise datapath with output skid.
// Depends on gn2d_pkg.
module gn2d_back #(
    parameter int FRAC_BITS  = gn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  gn2d_pkg::gn2d_item_t q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [18:0]          out_noise
);
    localparam int IW   = $clog2(gn2d_pkg::TABLE_SIZE);
    localparam int F    = FRAC_BITS;
    localparam int GW   = gn2d_pkg::COORD_W - F;
    localparam int TW   = F + 1;
    localparam int DW   = F + 2;
    localparam int NS   = 8;
    localparam logic [TW+1:0] THREE_ONE = (TW + 2)'(3) << F;

    // six copies of the permutation table and four of the gradient table for one-per-cycle reads while not stalled
    logic [7:0]  perm0_mem [gn2d_pkg::TABLE_SIZE];
    logic [7:0]  perm1_mem [gn2d_pkg::TABLE_SIZE];
    logic [7:0]  perm2_mem [gn2d_pkg::TABLE_SIZE];
    logic [7:0]  perm3_mem [gn2d_pkg::TABLE_SIZE];
    logic [7:0]  permh0_mem [gn2d_pkg::TABLE_SIZE];
    logic [7:0]  permh1_mem [gn2d_pkg::TABLE_SIZE];
    logic [31:0] grad0_mem [gn2d_pkg::TABLE_SIZE];
    logic [31:0] grad1_mem [gn2d_pkg::TABLE_SIZE];
    logic [31:0] grad2_mem [gn2d_pkg::TABLE_SIZE];
    logic [31:0] grad3_mem [gn2d_pkg::TABLE_SIZE];

    logic [NS-1:0] v_reg;
    logic          adv;
    logic          skid_valid_reg, out_valid_reg;
    logic [18:0]   skid_reg, out_reg;
    logic          gw_valid_reg;
    logic [IW-1:0] gw_idx_reg;
    logic [31:0]   gw_data_reg;

    // stall the pipeline only when everything is full downstream
    assign adv = !(out_valid_reg && skid_valid_reg);
    assign q_ready = adv;

    logic fire, do_eval, do_perm, do_grad;
    assign fire    = q_valid && q_ready;
    assign do_eval = fire && (q_item.op == gn2d_pkg::OP_EVAL);
    assign do_perm = fire && (q_item.op == gn2d_pkg::OP_LOAD_PERM);
    assign do_grad = fire && (q_item.op == gn2d_pkg::OP_LOAD_GRAD);

    function automatic logic [IW-1:0] modt(input logic [GW:0] v);
        return v[IW-1:0];
    endfunction

    // gradient writes land one advance later, after the read of an item just ahead
    always_ff @(posedge aclk) begin
        if (do_perm) begin
            perm0_mem[q_item.table_index[IW-1:0]] <= q_item.perm_value;
            perm1_mem[q_item.table_index[IW-1:0]] <= q_item.perm_value;
            perm2_mem[q_item.table_index[IW-1:0]] <= q_item.perm_value;
            perm3_mem[q_item.table_index[IW-1:0]] <= q_item.perm_value;
            permh0_mem[q_item.table_index[IW-1:0]] <= q_item.perm_value;
            permh1_mem[q_item.table_index[IW-1:0]] <= q_item.perm_value;
        end
        if (adv) begin
            gw_idx_reg  <= q_item.table_index[IW-1:0];
            gw_data_reg <= {q_item.grad_y, q_item.grad_x};
        end
        if (adv && gw_valid_reg) begin
            grad0_mem[gw_idx_reg] <= gw_data_reg;
            grad1_mem[gw_idx_reg] <= gw_data_reg;
            grad2_mem[gw_idx_reg] <= gw_data_reg;
            grad3_mem[gw_idx_reg] <= gw_data_reg;
        end
    end

    // stage 1: split coordinates, first hash read
    logic [GW:0]  s1_gx_reg, s1_gy_reg;
    logic [F-1:0] s1_fx_reg, s1_fy_reg;
    logic [7:0]   s1_p0_reg, s1_p1_reg;
    logic [GW:0]  gx_w, gy_w;
    assign gx_w = {1'b0, q_item.coord_x[31:F]};
    assign gy_w = {1'b0, q_item.coord_y[31:F]};

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_gx_reg <= gx_w;
            s1_gy_reg <= gy_w;
            s1_fx_reg <= q_item.coord_x[F-1:0];
            s1_fy_reg <= q_item.coord_y[F-1:0];
            s1_p0_reg <= permh0_mem[modt(gx_w)];
            s1_p1_reg <= permh1_mem[modt(gx_w + (GW + 1)'(1))];
        end
    end

    // stage 2: second hash read, fade square terms
    logic [7:0]   s2_h_reg [4];
    logic [F-1:0] s2_fx_reg, s2_fy_reg;
    logic [TW-1:0] tx0, ty0;
    logic [TW-1:0] s2_t_reg [4];
    logic [2*TW-1:0] s2_sq_reg [4];
    assign tx0 = TW'(1) << F;
    assign ty0 = TW'(1) << F;

    logic [TW-1:0] t_in [4];
    assign t_in[0] = tx0 - TW'(s1_fx_reg);
    assign t_in[1] = TW'(s1_fx_reg);
    assign t_in[2] = ty0 - TW'(s1_fy_reg);
    assign t_in[3] = TW'(s1_fy_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_h_reg[0] <= perm0_mem[modt(s1_gy_reg + (GW + 1)'(s1_p0_reg))];
            s2_h_reg[1] <= perm1_mem[modt(s1_gy_reg + (GW + 1)'(s1_p0_reg) + (GW + 1)'(1))];
            s2_h_reg[2] <= perm2_mem[modt(s1_gy_reg + (GW + 1)'(s1_p1_reg))];
            s2_h_reg[3] <= perm3_mem[modt(s1_gy_reg + (GW + 1)'(s1_p1_reg) + (GW + 1)'(1))];
            s2_fx_reg <= s1_fx_reg;
            s2_fy_reg <= s1_fy_reg;
            for (int i = 0; i < 4; i++) begin
                s2_t_reg[i]  <= t_in[i];
                s2_sq_reg[i] <= (2 * TW)'(t_in[i]) * (2 * TW)'(t_in[i]);
            end
        end
    end

    // stage 3: gradient read, fade second product
    logic [31:0]  s3_g_reg [4];
    logic [F-1:0] s3_fx_reg, s3_fy_reg;
    logic [TW+TW+1:0] s3_fd_reg [4];
    logic [TW-1:0] t2 [4];
    logic [TW+1:0] k  [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            t2[i] = TW'(s2_sq_reg[i] >> F);
            k[i]  = THREE_ONE - (TW + 2)'({s2_t_reg[i], 1'b0});
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_g_reg[0] <= grad0_mem[s2_h_reg[0][IW-1:0]];
            s3_g_reg[1] <= grad1_mem[s2_h_reg[1][IW-1:0]];
            s3_g_reg[2] <= grad2_mem[s2_h_reg[2][IW-1:0]];
            s3_g_reg[3] <= grad3_mem[s2_h_reg[3][IW-1:0]];
            s3_fx_reg <= s2_fx_reg;
            s3_fy_reg <= s2_fy_reg;
            for (int i = 0; i < 4; i++) begin
                s3_fd_reg[i] <= (2 * TW + 2)'(t2[i]) * (2 * TW + 2)'(k[i]);
            end
        end
    end

    // stage 4: gradient products, corner weight product
    logic signed [DW-1:0] dx [4], dy [4];
    logic signed [DW+16:0] s4_px_reg [4], s4_py_reg [4];
    logic [TW-1:0] w [4];
    logic [2*TW-1:0] s4_w_reg [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w[i] = TW'(s3_fd_reg[i] >> F);
        end
        dx[0] = $signed({2'b00, s3_fx_reg});
        dx[1] = dx[0];
        dx[2] = $signed({2'b00, s3_fx_reg}) - $signed(DW'(1) << F);
        dx[3] = dx[2];
        dy[0] = $signed({2'b00, s3_fy_reg});
        dy[2] = dy[0];
        dy[1] = $signed({2'b00, s3_fy_reg}) - $signed(DW'(1) << F);
        dy[3] = dy[1];
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                s4_px_reg[i] <= (DW + 17)'($signed(s3_g_reg[i][15:0])) * (DW + 17)'(dx[i]);
                s4_py_reg[i] <= (DW + 17)'($signed(s3_g_reg[i][31:16])) * (DW + 17)'(dy[i]);
            end
            s4_w_reg[0] <= (2 * TW)'(w[0]) * (2 * TW)'(w[2]);
            s4_w_reg[1] <= (2 * TW)'(w[0]) * (2 * TW)'(w[3]);
            s4_w_reg[2] <= (2 * TW)'(w[1]) * (2 * TW)'(w[2]);
            s4_w_reg[3] <= (2 * TW)'(w[1]) * (2 * TW)'(w[3]);
        end
    end

    // stage 5: dot sum and shift
    logic signed [DW+1:0] s5_dot_reg [4];
    logic [TW-1:0] s5_w_reg [4];
    logic signed [DW+17:0] dsum [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            dsum[i] = (DW + 18)'(s4_px_reg[i]) + (DW + 18)'(s4_py_reg[i]);
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                s5_dot_reg[i] <= (DW + 2)'(dsum[i] >>> 15);
                s5_w_reg[i]   <= TW'(s4_w_reg[i] >> F);
            end
        end
    end

    // stage 6: weighted terms
    logic signed [DW+TW+2:0] s6_p_reg [4];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                s6_p_reg[i] <= (DW + TW + 3)'(s5_dot_reg[i]) *
                               (DW + TW + 3)'($signed({1'b0, s5_w_reg[i]}));
            end
        end
    end

    // stage 7: pairwise sums
    localparam int SW = DW + 5;
    logic signed [SW-1:0] term [4];
    logic signed [SW-1:0] s7_a_reg, s7_b_reg;
    always_comb begin
        for (int i = 0; i < 4; i++) term[i] = SW'(s6_p_reg[i] >>> F);
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_a_reg <= term[0] + term[1];
            s7_b_reg <= term[2] + term[3];
        end
    end

    // stage 8: total and rescale to 16 fraction bits
    localparam int RW = SW + 17;
    logic signed [RW-1:0] s8_r_reg;
    logic signed [SW-1:0] tot;
    assign tot = s7_a_reg + s7_b_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (F >= 16) s8_r_reg <= RW'(tot >>> (F >= 16 ? F - 16 : 0));
            else         s8_r_reg <= RW'(tot) <<< (F < 16 ? 16 - F : 0);
        end
    end

    // saturate into the output register or the skid
    logic signed [RW-1:0] lo, hi;
    logic [18:0] sat;
    assign lo = -RW'(262144);
    assign hi = RW'(262143);
    always_comb begin
        if (s8_r_reg < lo)      sat = 19'h40000;
        else if (s8_r_reg > hi) sat = 19'h3FFFF;
        else                    sat = s8_r_reg[18:0];
    end

    // valid chain and output register with skid
    logic res_v;
    assign res_v = v_reg[NS-1];
    assign out_valid = out_valid_reg;
    assign out_noise = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg          <= '0;
            gw_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (adv) v_reg <= {v_reg[NS-2:0], do_eval};
            if (adv) gw_valid_reg <= do_grad;
            if (!out_valid_reg || out_ready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    out_reg        <= skid_reg;
                    skid_valid_reg <= adv && res_v;
                    skid_reg       <= sat;
                end else begin
                    out_valid_reg <= adv && res_v;
                    out_reg       <= sat;
                end
            end else if (adv && res_v) begin
                skid_valid_reg <= 1'b1;
                skid_reg       <= sat;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg) else $error("skid full with output empty");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> out_valid_reg) else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> $stable(out_reg))
        else $error("result changed while waiting");
endmodule

// File: hw/rtl/gradient_noise_2d_core.sv
// gradient_noise_2d_core: top level of the 2D gradient noise block.
// Depends on gn2d_pkg, gn2d_front, gn2d_back.
//
// channel   dir   payload
// s_axis    in    op, table_index, perm_value, grad_x, grad_y, coord_x, coord_y
// m_axis    out   noise_value (Q3.16, saturated)
//
// One item per cycle while neither side stalls; an evaluation passes through the queue,
// eight datapath stages with a table copy per lookup, then the output register. Loads
// are seen by every later evaluation; op 3 is dropped by the front. A two-entry queue
// and a one-entry output skid let either side stall. aresetn is synchronous; tables
// are undefined until loaded.
module gradient_noise_2d_core #(
    parameter int FRAC_BITS  = gn2d_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[1:0], table_index[9:2], perm_value[17:10], grad_x[33:18], grad_y[49:34],
    // coord_x[81:50], coord_y[113:82], zero fill to 119
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // noise_value[18:0], zero fill to 23
    output logic [23:0]  m_tdata
);
    gn2d_pkg::gn2d_item_t in_item, q_item;
    logic q_valid, q_ready;
    logic [18:0] noise;

    assign in_item.op          = s_tdata[1:0];
    assign in_item.table_index = s_tdata[9:2];
    assign in_item.perm_value  = s_tdata[17:10];
    assign in_item.grad_x      = s_tdata[33:18];
    assign in_item.grad_y      = s_tdata[49:34];
    assign in_item.coord_x     = s_tdata[81:50];
    assign in_item.coord_y     = s_tdata[113:82];

    gn2d_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    gn2d_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_noise(noise)
    );

    assign m_tdata = {5'd0, noise};
endmodule

// File: verif/gradient_noise_2d_core_tb.sv
// Testbench for gradient_noise_2d_core: loads permutation and gradient tables, evaluates
// noise points and checks every result against a built-in fixed-point predictor.
// Depends on gn2d_pkg and gradient_noise_2d_core.
`timescale 1ns / 1ps

module gradient_noise_2d_core_tb;

    localparam int NTAB = 256;
    localparam int GRAD_LOADS = 64;
    localparam int FB = 16;
    localparam longint ONE = 64'sd1 << FB;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [119:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;

    gradient_noise_2d_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    logic [7:0] perm_copy [NTAB];
    logic [31:0] grad_copy [NTAB];
    bit perm_written [NTAB];
    bit grad_written [NTAB];
    logic [18:0] noise_expected [$];
    int error_count = 0;
    int idle_cycles = 0;
    bit idling_on = 1'b1;
    bit hold_sink = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint smoothstep(input longint t);
        longint t2;
        t2 = (t * t) >>> FB;
        return (t2 * (3 * ONE - 2 * t)) >>> FB;
    endfunction

    function automatic longint corner_term(input logic [31:0] cx, input logic [31:0] cy,
                                           input longint dx, input longint dy,
                                           input longint wx, input longint wy);
        logic [7:0] p, h;
        logic [31:0] g;
        longint gx, gy, dot, w;
        p = perm_copy[cx[7:0]];
        h = perm_copy[8'(cy + 32'(p))];
        g = grad_copy[h];
        gx = longint'($signed(g[15:0]));
        gy = longint'($signed(g[31:16]));
        dot = floor_shr(gx * dx + gy * dy, 15);
        w = (wx * wy) >>> FB;
        return floor_shr(dot * w, FB);
    endfunction

    function automatic logic [18:0] noise_at(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] gx, gy;
        longint fx, fy, wx0, wx1, wy0, wy1, acc;
        gx = x >> FB;
        gy = y >> FB;
        fx = longint'(x[FB-1:0]);
        fy = longint'(y[FB-1:0]);
        wx0 = smoothstep(ONE - fx);
        wx1 = smoothstep(fx);
        wy0 = smoothstep(ONE - fy);
        wy1 = smoothstep(fy);
        acc = corner_term(gx, gy, fx, fy, wx0, wy0)
            + corner_term(gx, gy + 1, fx, fy - ONE, wx0, wy1)
            + corner_term(gx + 1, gy, fx - ONE, fy, wx1, wy0)
            + corner_term(gx + 1, gy + 1, fx - ONE, fy - ONE, wx1, wy1);
        if (acc < -262144) acc = -262144;
        if (acc > 262143) acc = 262143;
        return acc[18:0];
    endfunction

    // a point is safe when every corner it reaches reads written entries
    function automatic bit point_safe(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] cx, cy;
        logic [7:0] h;
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                cx = (x >> FB) + i;
                cy = (y >> FB) + j;
                if (!perm_written[cx[7:0]]) return 1'b0;
                h = 8'(cy + 32'(perm_copy[cx[7:0]]));
                if (!perm_written[h]) return 1'b0;
                if (!grad_written[perm_copy[h]]) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic send_item(input gn2d_pkg::gn2d_item_t it);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tdata <= {6'b0, it.coord_y, it.coord_x, it.grad_y, it.grad_x,
                    it.perm_value, it.table_index, it.op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (it.op)
            gn2d_pkg::OP_LOAD_PERM: begin
                perm_copy[it.table_index] = it.perm_value;
                perm_written[it.table_index] = 1'b1;
            end
            gn2d_pkg::OP_LOAD_GRAD: begin
                grad_copy[it.table_index] = {it.grad_y, it.grad_x};
                grad_written[it.table_index] = 1'b1;
            end
            gn2d_pkg::OP_EVAL: noise_expected.push_back(noise_at(it.coord_x, it.coord_y));
            default: ;
        endcase
        @(negedge aclk);
    endtask

    function automatic gn2d_pkg::gn2d_item_t make_item(input logic [1:0] op,
                                                       input logic [7:0] idx,
                                                       input logic [7:0] pv,
                                                       input logic [15:0] gx,
                                                       input logic [15:0] gy,
                                                       input logic [31:0] x,
                                                       input logic [31:0] y);
        gn2d_pkg::gn2d_item_t it;
        it.op = op; it.table_index = idx; it.perm_value = pv;
        it.grad_x = gx; it.grad_y = gy; it.coord_x = x; it.coord_y = y;
        return it;
    endfunction

    function automatic gn2d_pkg::gn2d_item_t rand_item(input logic [1:0] op);
        return make_item(op, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                         $urandom, $urandom);
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (noise_expected.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    // every permutation entry gets a value below GRAD_LOADS, so those gradients cover all hashes
    task automatic test_table_load();
        for (int i = 0; i < NTAB; i++)
            send_item(make_item(gn2d_pkg::OP_LOAD_PERM, 8'(i),
                                8'($urandom_range(0, GRAD_LOADS - 1)), 16'($urandom),
                                16'($urandom), $urandom, $urandom));
        for (int i = 0; i < GRAD_LOADS; i++)
            send_item(make_item(gn2d_pkg::OP_LOAD_GRAD, 8'(i), 8'($urandom), 16'($urandom),
                                16'($urandom), $urandom, $urandom));
    endtask

    task automatic test_directed();
        send_item(make_item(gn2d_pkg::OP_LOAD_GRAD, 8'd0, 8'hff, 16'h8000, 16'h8000, '1, '1));
        send_item(make_item(gn2d_pkg::OP_LOAD_GRAD, 8'd255, 8'h00, 16'h7fff, 16'h7fff, '0, '0));
        send_item(make_item(gn2d_pkg::OP_LOAD_GRAD, 8'd1, 8'h00, 16'h7fff, 16'h8000, '0, '0));
        send_item(make_item(gn2d_pkg::OP_LOAD_PERM, 8'd255, 8'd0, 16'hffff, 16'hffff, '1, '1));
        send_item(make_item(gn2d_pkg::OP_LOAD_PERM, 8'd0, 8'd255, 16'h0, 16'h0, '0, '0));
        // unused op: no effect, no result
        send_item(make_item(OP_UNUSED, 8'd0, 8'd7, 16'h1234, 16'h1234, '1, '1));
        send_item(make_item(gn2d_pkg::OP_EVAL, '1, '1, '1, '1, 32'h0, 32'h0));
        send_item(make_item(gn2d_pkg::OP_EVAL, '0, '0, '0, '0, 32'hffff_ffff, 32'hffff_ffff));
        send_item(make_item(gn2d_pkg::OP_EVAL, '0, '0, '0, '0, 32'h0000_8000, 32'h0000_8000));
        send_item(make_item(gn2d_pkg::OP_EVAL, '0, '0, '0, '0, 32'hffff_0000, 32'h0000_ffff));
        send_item(make_item(gn2d_pkg::OP_EVAL, '0, '0, '0, '0, 32'h0001_0001, 32'h7fff_8000));
        send_item(make_item(gn2d_pkg::OP_EVAL, '0, '0, '0, '0, 32'h00ff_4000, 32'h0100_c000));
        // extreme negative gradients on a few entries
        for (int i = 0; i < 4; i++)
            send_item(make_item(gn2d_pkg::OP_LOAD_GRAD, 8'(i + 2), '0, 16'h8000, 16'h8000,
                                '0, '0));
        send_item(make_item(gn2d_pkg::OP_EVAL, '0, '0, '0, '0, 32'h0003_5555, 32'h0009_aaaa));
        send_item(make_item(gn2d_pkg::OP_EVAL, '0, '0, '0, '0, 32'h1234_abcd, 32'hfedc_0123));
    endtask

    task automatic test_random(input int n);
        gn2d_pkg::gn2d_item_t it;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0) it = rand_item(OP_UNUSED);
            else if (r < 3) it = rand_item(gn2d_pkg::OP_LOAD_PERM);
            else if (r < 5) it = rand_item(gn2d_pkg::OP_LOAD_GRAD);
            else it = rand_item(gn2d_pkg::OP_EVAL);
            if (it.op == gn2d_pkg::OP_EVAL && !point_safe(it.coord_x, it.coord_y))
                it.op = OP_UNUSED;
            send_item(it);
        end
    endtask

    task automatic test_backpressure();
        gn2d_pkg::gn2d_item_t it;
        hold_sink = 1'b1;
        for (int i = 0; i < 30; i++) begin
            it = rand_item(gn2d_pkg::OP_EVAL);
            if (!point_safe(it.coord_x, it.coord_y)) it.op = OP_UNUSED;
            send_item(it);
        end
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (noise_expected.size() == 0)
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            else if (m_tdata[18:0] !== noise_expected[0])
                report_mismatch($sformatf("noise_value got %0d want %0d",
                    $signed(m_tdata[18:0]), $signed(noise_expected.pop_front())));
            else
                void'(noise_expected.pop_front());
        end
    end

    // sink: random stalls, plus one long hold-off while the source keeps pushing
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_tready <= 1'b0;
                n = 0;
                while (n < 60) begin
                    @(negedge aclk);
                    n++;
                end
                hold_sink = 1'b0;
            end
            if (idling_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_table_load();
        test_directed();
        wait_drained();
        test_random(80);
        test_backpressure();
        test_random(50);
        wait_drained();
        idling_on = 1'b0;
        test_random(50);
        wait_drained();
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: gradient_noise_2d_core.f
hw/rtl/gn2d_pkg.sv
hw/rtl/gn2d_front.sv
hw/rtl/gn2d_back.sv
hw/rtl/gradient_noise_2d_core.sv
verif/gradient_noise_2d_core_tb.sv
